[rtl/gp_kernel_covariance_defines.svh]
// Assertion macros shared by the kernel covariance RTL.
`ifndef GP_KERNEL_COVARIANCE_DEFINES_SVH
`define GP_KERNEL_COVARIANCE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define GPK_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpk assertion failed");
// Next-cycle implication, disabled during reset.
`define GPK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpk assertion failed");
`else
`define GPK_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define GPK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/gpk_pkg.sv]
// Types and constants shared by the kernel covariance modules.
package gpk_pkg;

   // One input word: one dimension of a point pair.
   typedef struct packed {
      logic signed [31:0] first_coord;
      logic signed [31:0] second_coord;
      logic [31:0]        inv_length_sq;
      logic               last_element;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [31:0] kernel_value;
      logic        saturated;
   } rsp_type;

   // Finished squared distance handed from front to back.
   typedef struct packed {
      logic [63:0] r2;
      logic        ovf;
   } dist_type;

   // Shared multiplier request and response.
   typedef struct packed {
      logic        start;
      logic        shift32;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic [63:0] result;
   } mul_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_ROOT, ST_RMUL, ST_FIX, ST_EXP,
      ST_HMUL, ST_SQ, ST_PMUL, ST_AMUL, ST_OUT
   } back_state_type;

   localparam logic [1:0] MODE_SE  = 2'd0;
   localparam logic [1:0] MODE_M15 = 2'd1;
   localparam logic [1:0] MODE_M25 = 2'd2;

   localparam logic [1:0] CSR_KERNEL_MODE = 2'd0;
   localparam logic [1:0] CSR_ALPHA       = 2'd1;

   localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
   localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;
   localparam logic [63:0] ONE32 = 64'h0000_0001_0000_0000;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int SQRT_STEPS   = 48;
   localparam int HORNER_TERMS = 20;
   localparam int SQUARINGS    = 5;

endpackage

[rtl/gpk_mul.sv]
// Shared 64x64 multiplier built from one 32x32 product per cycle.
module gpk_mul (
   input  logic                clock,
   input  logic                reset,
   input  gpk_pkg::mul_req_type mreq,
   output gpk_pkg::mul_rsp_type mrsp
);
   import gpk_pkg::*;

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic         sel_ff, sel_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  opa, opb;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   // Partial product selection and placement.
   always_comb begin
      opa = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      opb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp  = opa * opb;
      unique case (cnt_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // Sequencing of the four partial products.
   always_comb begin
      a_in = a_ff; b_in = b_ff; sel_in = sel_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; acc_in = acc_ff;
      if (mreq.start) begin
         a_in = mreq.a; b_in = mreq.b; sel_in = mreq.shift32;
         cnt_in = 2'd0; busy_in = 1'b1; acc_in = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      sel_ff <= sel_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
   end

   // Scale down and saturate.
   always_comb begin
      mrsp.done = done_ff;
      if (sel_ff) begin
         mrsp.ovf    = (acc_ff[127:96] != 32'd0);
         mrsp.result = acc_ff[95:32];
      end else begin
         mrsp.ovf    = (acc_ff[127:126] != 2'd0);
         mrsp.result = acc_ff[125:62];
      end
      if (mrsp.ovf) mrsp.result = '1;
   end

endmodule

[rtl/gpk_queue.sv]
// Short queue of finished distances between front and back.
module gpk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpk_pkg::dist_type push_data,
   input  logic              pop,
   output gpk_pkg::dist_type pop_data,
   output logic              full,
   output logic              empty
);
   import gpk_pkg::*;

   dist_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

[rtl/gpk_front.sv]
// Front end: per-dimension weighted square and distance accumulation.
module gpk_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gpk_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output gpk_pkg::dist_type q_data
);
   import gpk_pkg::*;

   logic        adv;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        l1_ff, l2_ff, l3_ff, l4_ff;
   logic [31:0] a1_ff, w1_ff, w2_ff;
   logic [63:0] sq2_ff;
   logic [63:0] plo3_ff, phi3_ff;
   logic [63:0] term4_ff;
   logic        tovf4_ff;
   logic [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [32:0] diff;
   logic [31:0] a_abs;
   logic [95:0] prod;
   logic [64:0] sum;
   logic [63:0] acc_new;
   logic        ovf_new;

   // The whole pipe moves together while the queue has room.
   assign adv       = !q_full;
   assign req_stall = !adv;

   // Absolute coordinate difference and product combine.
   always_comb begin
      diff  = {req_data.first_coord[31], req_data.first_coord}
            - {req_data.second_coord[31], req_data.second_coord};
      a_abs = diff[32] ? 32'(-diff) : diff[31:0];
      prod  = {phi3_ff, 32'd0} + {32'd0, plo3_ff};
   end

   // Pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
      if (adv) begin
         a1_ff    <= a_abs;
         w1_ff    <= req_data.inv_length_sq;
         l1_ff    <= req_data.last_element;
         sq2_ff   <= a1_ff * a1_ff;
         w2_ff    <= w1_ff;
         l2_ff    <= l1_ff;
         plo3_ff  <= sq2_ff[31:0] * w2_ff;
         phi3_ff  <= sq2_ff[63:32] * w2_ff;
         l3_ff    <= l2_ff;
         tovf4_ff <= (prod[95:80] != 16'd0);
         term4_ff <= (prod[95:80] != 16'd0) ? '1 : prod[79:16];
         l4_ff    <= l3_ff;
      end
   end

   // Saturating accumulation and hand-off on the last dimension.
   always_comb begin
      sum     = {1'b0, acc_ff} + {1'b0, term4_ff};
      acc_new = sum[64] ? '1 : sum[63:0];
      ovf_new = ovf_ff | tovf4_ff | sum[64];
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      q_push  = 1'b0;
      q_data  = '{r2: acc_new, ovf: ovf_new};
      if (adv && v4_ff) begin
         if (l4_ff) begin
            q_push = 1'b1;
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = acc_new;
            ovf_in = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

[rtl/gpk_back.sv]
// Back end: square root, exponential and scaling for one finished distance.
module gpk_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  gpk_pkg::dist_type    q_data,
   output logic                 q_pop,
   input  logic [1:0]           kernel_mode,
   input  logic [31:0]          alpha,
   output gpk_pkg::mul_req_type mreq,
   input  gpk_pkg::mul_rsp_type mrsp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gpk_pkg::rsp_type     rsp_data
);
   import gpk_pkg::*;

   back_state_type state_ff, state_in;
   logic [63:0] r2_ff, r2_in, vsh_ff, vsh_in, x_ff, x_in;
   logic [63:0] poly_ff, poly_in, f_ff, f_in, s_ff, s_in;
   logic [43:0] root_ff, root_in;
   logic [45:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in, q0_ff, q0_in;
   logic [4:0]  dvs_ff, dvs_in, k_ff, k_in;
   logic [2:0]  sq_ff, sq_in;
   logic        divp_ff, divp_in, sat_ff, sat_in;
   logic [31:0] kern_ff, kern_in;

   logic [63:0] r2x3, r2x5, s_new, f_new;
   logic [45:0] rem_sh, trial;
   logic        rge;
   logic [43:0] root_nx;
   logic [63:0] pk, rfix, qfix;

   // Truncated reciprocal floor(2^62 / k) for the small divisors in use.
   function automatic logic [63:0] recip_q62(input logic [4:0] k);
      logic [63:0] r;
      unique case (k)
         5'd1:    r = ONE62;
         5'd2:    r = ONE62 / 64'd2;
         5'd3:    r = ONE62 / 64'd3;
         5'd4:    r = ONE62 / 64'd4;
         5'd5:    r = ONE62 / 64'd5;
         5'd6:    r = ONE62 / 64'd6;
         5'd7:    r = ONE62 / 64'd7;
         5'd8:    r = ONE62 / 64'd8;
         5'd9:    r = ONE62 / 64'd9;
         5'd10:   r = ONE62 / 64'd10;
         5'd11:   r = ONE62 / 64'd11;
         5'd12:   r = ONE62 / 64'd12;
         5'd13:   r = ONE62 / 64'd13;
         5'd14:   r = ONE62 / 64'd14;
         5'd15:   r = ONE62 / 64'd15;
         5'd16:   r = ONE62 / 64'd16;
         5'd17:   r = ONE62 / 64'd17;
         5'd18:   r = ONE62 / 64'd18;
         5'd19:   r = ONE62 / 64'd19;
         5'd20:   r = ONE62 / 64'd20;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Square root step and the quotient correction after a reciprocal multiply.
   // The reciprocal product is at most one below the true quotient.
   always_comb begin
      r2x3    = r2_ff + {r2_ff[62:0], 1'b0};
      r2x5    = r2_ff + {r2_ff[61:0], 2'b00};
      rem_sh  = {rem_ff[43:0], vsh_ff[63:62]};
      trial   = {root_ff, 2'b01};
      rge     = (rem_sh >= trial);
      root_nx = {root_ff[42:0], rge};
      pk      = q0_ff * 64'(dvs_ff);
      rfix    = quo_ff - pk;
      qfix    = (rfix >= 64'(dvs_ff)) ? q0_ff + 64'd1 : q0_ff;
      s_new   = ONE62 - qfix;
      f_new   = {x_ff[38:0], 25'd0};
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff; r2_in = r2_ff; vsh_in = vsh_ff; x_in = x_ff;
      poly_in = poly_ff; f_in = f_ff; s_in = s_ff; root_in = root_ff;
      rem_in = rem_ff; cnt_in = cnt_ff; quo_in = quo_ff; q0_in = q0_ff;
      dvs_in = dvs_ff; k_in = k_ff; sq_in = sq_ff; divp_in = divp_ff;
      sat_in = sat_ff; kern_in = kern_ff;
      mreq = '0;
      q_pop = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               r2_in = q_data.r2;
               sat_in = q_data.ovf;
               state_in = ST_START;
            end
         end
         ST_START: begin
            root_in = '0; rem_in = '0; cnt_in = '0;
            vsh_in = (kernel_mode == MODE_M25) ? r2x5 : r2x3;
            if (r2_ff[63:48] != 16'd0) begin
               kern_in = '0;
               state_in = ST_OUT;
            end else if (kernel_mode == MODE_M15 || kernel_mode == MODE_M25) begin
               state_in = ST_ROOT;
            end else begin
               x_in = {1'b0, r2_ff[63:1]};
               poly_in = ONE32;
               state_in = ST_EXP;
            end
         end
         ST_ROOT: begin
            vsh_in = {vsh_ff[61:0], 2'b00};
            rem_in = rge ? rem_sh - trial : rem_sh;
            root_in = root_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SQRT_STEPS - 1)) begin
               x_in = {20'd0, root_nx};
               poly_in = ONE32 + {20'd0, root_nx};
               if (kernel_mode == MODE_M25) begin
                  // Divide 5*r2 by three through the shared multiplier.
                  quo_in = r2x5; dvs_in = 5'd3; divp_in = 1'b1;
                  mreq.start = 1'b1; mreq.a = r2x5; mreq.b = recip_q62(5'd3);
                  state_in = ST_RMUL;
               end else begin
                  state_in = ST_EXP;
               end
            end
         end
         ST_RMUL: begin
            if (mrsp.done) begin
               q0_in = mrsp.result;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (divp_ff) begin
               poly_in = poly_ff + qfix;
               state_in = ST_EXP;
            end else begin
               s_in = s_new;
               mreq.start = 1'b1;
               if (k_ff == 5'd1) begin
                  // Horner series done, start the squarings.
                  mreq.a = s_new; mreq.b = s_new;
                  sq_in = '0;
                  state_in = ST_SQ;
               end else begin
                  mreq.a = f_ff; mreq.b = s_new;
                  k_in = k_ff - 5'd1;
                  state_in = ST_HMUL;
               end
            end
         end
         ST_EXP: begin
            if (x_ff[63:37] != 27'd0) begin
               kern_in = '0;
               state_in = ST_OUT;
            end else begin
               f_in = f_new; s_in = ONE62; k_in = 5'(HORNER_TERMS);
               mreq.start = 1'b1; mreq.a = f_new; mreq.b = ONE62;
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            if (mrsp.done) begin
               // Divide the product by the term index.
               quo_in = mrsp.result; dvs_in = k_ff; divp_in = 1'b0;
               mreq.start = 1'b1; mreq.a = mrsp.result; mreq.b = recip_q62(k_ff);
               state_in = ST_RMUL;
            end
         end
         ST_SQ: begin
            if (mrsp.done) begin
               s_in = mrsp.result;
               mreq.start = 1'b1;
               mreq.b = mrsp.result;
               if (sq_ff == 3'(SQUARINGS - 1)) begin
                  mreq.a = poly_ff;
                  state_in = ST_PMUL;
               end else begin
                  mreq.a = mrsp.result;
                  sq_in = sq_ff + 3'd1;
               end
            end
         end
         ST_PMUL: begin
            if (mrsp.done) begin
               sat_in = sat_ff | mrsp.ovf;
               mreq.start = 1'b1; mreq.shift32 = 1'b1;
               mreq.a = {32'd0, alpha}; mreq.b = mrsp.result;
               state_in = ST_AMUL;
            end
         end
         ST_AMUL: begin
            if (mrsp.done) begin
               if (mrsp.ovf || mrsp.result[63:32] != 32'd0) begin
                  kern_in = '1;
                  sat_in = 1'b1;
               end else begin
                  kern_in = mrsp.result[31:0];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data = '{kernel_value: kern_ff, saturated: sat_ff};

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      r2_ff <= r2_in; vsh_ff <= vsh_in; x_ff <= x_in; poly_ff <= poly_in;
      f_ff <= f_in; s_ff <= s_in; root_ff <= root_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; quo_ff <= quo_in; q0_ff <= q0_in; dvs_ff <= dvs_in;
      k_ff <= k_in; sq_ff <= sq_in; divp_ff <= divp_in; sat_ff <= sat_in;
      kern_ff <= kern_in;
   end

endmodule

[rtl/gp_kernel_covariance.sv]
// Top level of the Gaussian-process kernel covariance block.
// The front end takes one dimension word per cycle and adds its weighted squared
// distance through a pipeline; a point pair's last word hands the distance to a
// four-entry queue. The back end then works one pair at a time. Most of its work
// is the exponential's twenty Horner terms, each two passes of the shared
// multiplier (the product, then a reciprocal multiply for the divide by the term
// index) and a correction step. Matern 1.5 and 2.5 first take a square root, and
// Matern 2.5 a divide by three as well.
// The front stalls only when the queue is full.
`include "gp_kernel_covariance_defines.svh"
module gp_kernel_covariance (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gpk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gpk_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import gpk_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] alpha_ff, alpha_in;
   logic        q_push, q_pop, q_full, q_empty;
   dist_type    q_wdata, q_rdata;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_comb begin
      mode_in  = mode_ff;
      alpha_in = alpha_ff;
      if (csr_valid) begin
         if (csr_index == CSR_KERNEL_MODE) mode_in = csr_data[1:0];
         else if (csr_index == CSR_ALPHA)  alpha_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SE;
         alpha_ff <= ALPHA_RESET;
      end else begin
         mode_ff  <= mode_in;
         alpha_ff <= alpha_in;
      end
   end

   gpk_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
   );

   gpk_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_wdata), .pop(q_pop), .pop_data(q_rdata),
      .full(q_full), .empty(q_empty)
   );

   gpk_mul u_mul (
      .clock(clock), .reset(reset), .mreq(mreq), .mrsp(mrsp)
   );

   gpk_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
      .kernel_mode(mode_ff), .alpha(alpha_ff),
      .mreq(mreq), .mrsp(mrsp),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Queue is never written full or read empty; a stalled result holds.
   `GPK_ASSERT_IMPL(a_no_push_full, clock, reset, q_push, !q_full)
   `GPK_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `GPK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule
